// File: design/dff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dff_pkg
// Shared types and constants of the decimal field formatter pipeline.
// ----------------------------------------------------------------------------
package dff_pkg;

    localparam int VALUE_W    = 17;
    localparam int CHAR_W     = 6;
    localparam int DIGIT_W    = 4;
    localparam int NUM_PLACES = 4;
    localparam int PLACE_W    = 2;
    localparam int PROD_W     = VALUE_W + DIGIT_W;
    localparam int NUM_STAGES = NUM_PLACES + 1;

    localparam logic [VALUE_W-1:0] FIELD_MAX  = VALUE_W'(99999);
    localparam logic [CHAR_W-1:0]  CHAR_SPACE = CHAR_W'(32);
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = CHAR_W'(48);

    localparam logic [VALUE_W-1:0] PLACE_WEIGHT [NUM_PLACES] = '{
        VALUE_W'(10000), VALUE_W'(1000), VALUE_W'(100), VALUE_W'(10)
    };

    typedef logic [DIGIT_W-1:0] t_digit;

    typedef struct packed {
        logic [VALUE_W-1:0]          rem;
        t_digit [NUM_PLACES-1:0]     digits;
        logic                        ovf;
    } t_item;

endpackage

// File: design/decimal_field_formatter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_field_formatter_unit
// Formats a 17-bit unsigned number as a five-character right-aligned ASCII
// decimal field, leading zeros shown as spaces and the units place always a
// digit. Values above 99999 give "99999" with o_overflow set. The pipeline
// has six register stages (saturate, one stage per leading decimal place,
// ASCII output register), and each result passes through them in that
// order. One transaction is taken every cycle; a low i_ready stalls the
// stages without loss.
// ----------------------------------------------------------------------------
module decimal_field_formatter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dff_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dff_pkg::CHAR_W-1:0]    o_char_ten_thousands,
    output logic [dff_pkg::CHAR_W-1:0]    o_char_thousands,
    output logic [dff_pkg::CHAR_W-1:0]    o_char_hundreds,
    output logic [dff_pkg::CHAR_W-1:0]    o_char_tens,
    output logic [dff_pkg::CHAR_W-1:0]    o_char_units,
    output logic                          o_overflow
);
    import dff_pkg::*;

    logic               c_valid [NUM_STAGES];
    logic               c_ready [NUM_STAGES];
    t_item              c_item  [NUM_STAGES];
    logic [CHAR_W-1:0]  chars   [NUM_STAGES];

    dff_front_stage u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (i_value),
        .o_valid (c_valid[0]),
        .i_ready (c_ready[0]),
        .o_item  (c_item[0])
    );

    for (genvar g = 0; g < NUM_PLACES; g++) begin : g_place
        dff_digit_stage u_digit (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_weight (PLACE_WEIGHT[g]),
            .i_place  (PLACE_W'(g)),
            .i_valid  (c_valid[g]),
            .o_ready  (c_ready[g]),
            .i_item   (c_item[g]),
            .o_valid  (c_valid[g+1]),
            .i_ready  (c_ready[g+1]),
            .o_item   (c_item[g+1])
        );
    end

    dff_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (c_valid[NUM_PLACES]),
        .o_ready    (c_ready[NUM_PLACES]),
        .i_item     (c_item[NUM_PLACES]),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_chars    (chars),
        .o_overflow (o_overflow)
    );

    assign o_char_ten_thousands = chars[0];
    assign o_char_thousands     = chars[1];
    assign o_char_hundreds      = chars[2];
    assign o_char_tens          = chars[3];
    assign o_char_units         = chars[4];

    localparam logic [CHAR_W-1:0] CHAR_NINE = CHAR_ZERO + CHAR_W'(9);

    a_units_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_units >= CHAR_ZERO && o_char_units <= CHAR_NINE))
        else $error("units place is not a digit");

    a_ovf_nines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_char_ten_thousands == CHAR_NINE &&
            o_char_thousands == CHAR_NINE && o_char_hundreds == CHAR_NINE &&
            o_char_tens == CHAR_NINE && o_char_units == CHAR_NINE))
        else $error("overflow result is not saturated");

    a_blank_1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char_ten_thousands != CHAR_SPACE) |->
            (o_char_thousands != CHAR_SPACE))
        else $error("blank after a printed digit");

    a_blank_2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char_thousands != CHAR_SPACE) |->
            (o_char_hundreds != CHAR_SPACE && o_char_tens != CHAR_SPACE))
        else $error("blank after a printed digit");

    a_no_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready || c_valid[0] && !c_ready[0])
        else $error("pipeline refused input with a free path");

endmodule

// File: design/dff_front_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dff_front_stage
// Input register: saturates the value to 99999 and flags overflow.
// ----------------------------------------------------------------------------
module dff_front_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dff_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output dff_pkg::t_item                o_item
);
    import dff_pkg::*;

    logic   r_valid;
    t_item  r_item;
    t_item  n_item;
    logic   load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_item        = '0;
        n_item.ovf    = (i_value > FIELD_MAX);
        n_item.rem    = n_item.ovf ? FIELD_MAX : i_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: design/dff_digit_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dff_digit_stage
// One pipeline stage: peels off the digit of one decimal place by compare
// against its nine multiples and keeps the remainder.
// ----------------------------------------------------------------------------
module dff_digit_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [dff_pkg::VALUE_W-1:0]   i_weight,
    input  logic [dff_pkg::PLACE_W-1:0]   i_place,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  dff_pkg::t_item                i_item,
    output logic                          o_valid,
    input  logic                          i_ready,
    output dff_pkg::t_item                o_item
);
    import dff_pkg::*;

    logic               r_valid;
    t_item              r_item;
    t_item              n_item;
    logic               load;
    t_digit             dig;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  sel;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        dig = '0;
        sel = '0;
        for (int k = 1; k <= 9; k++) begin
            prod = PROD_W'(k) * PROD_W'(i_weight);
            if (PROD_W'(i_item.rem) >= prod) begin
                dig = DIGIT_W'(k);
                sel = prod;
            end
        end
        n_item                 = i_item;
        n_item.digits[i_place] = dig;
        n_item.rem             = i_item.rem - sel[VALUE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: design/dff_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dff_out_stage
// Output register: maps digits to ASCII and blanks leading zeros.
// ----------------------------------------------------------------------------
module dff_out_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  dff_pkg::t_item                i_item,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dff_pkg::CHAR_W-1:0]    o_chars [dff_pkg::NUM_STAGES],
    output logic                          o_overflow
);
    import dff_pkg::*;

    logic               r_valid;
    logic [CHAR_W-1:0]  r_chars [NUM_STAGES];
    logic               r_ovf;
    logic [CHAR_W-1:0]  n_chars [NUM_STAGES];
    logic               started;
    logic               load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        started = 1'b0;
        for (int i = 0; i < NUM_PLACES; i++) begin
            started    = started || (i_item.digits[i] != '0);
            n_chars[i] = started ? (CHAR_ZERO + CHAR_W'(i_item.digits[i])) : CHAR_SPACE;
        end
        n_chars[NUM_PLACES] = CHAR_ZERO + CHAR_W'(i_item.rem[DIGIT_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_chars <= n_chars;
            r_ovf   <= i_item.ovf;
        end
    end

    assign o_valid    = r_valid;
    assign o_chars    = r_chars;
    assign o_overflow = r_ovf;

endmodule
